@@ hdl/olid_pkg.sv @@
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and codes for the ordered list block: request and result
// transactions, status and request codes, and the control bundle that drives
// the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

  // Field widths
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int STAT_W       = 3;
  localparam int CNT_W        = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int CAPACITY_MAX = 64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ENTRY     = 3'd4;

  // Input transaction
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Output transaction
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;
  } res_t;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic              insert;   // write value into the cell at index count
    logic              compare;  // latch value match for a delete
    logic              remove;   // close the gap behind the first match
    logic              rotate;   // move one place toward the head, head to tail
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage : olid_pkg

`default_nettype wire

@@ hdl/olid_cell.sv @@
// ----------------------------------------------------------------------------
// olid_cell
// One storage cell of the list chain. Holds one entry, compares it against
// the delete value, and takes its neighbor's entry on a remove or rotate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olid_cell
  import olid_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0] next_i,   // entry of the cell behind this one
  input  wire logic [DATA_W-1:0] head_i,   // entry of cell zero
  input  wire logic              hit_i,    // a match exists nearer the head
  output logic [DATA_W-1:0]      value_o,
  output logic                   hit_o
);

  logic [DATA_W-1:0] value_q, value_d;
  logic              match_q, match_d;
  logic              in_list;

  assign in_list = (CNT_W'(IDX) < ctrl_i.count);
  assign hit_o   = hit_i | match_q;
  assign value_o = value_q;

  // Next entry and match flag
  always_comb begin
    value_d = value_q;
    match_d = match_q;
    priority if (ctrl_i.insert) begin
      if (ctrl_i.count == CNT_W'(IDX)) value_d = ctrl_i.value;
    end else if (ctrl_i.compare) begin
      match_d = in_list && (value_q == ctrl_i.value);
    end else if (ctrl_i.remove) begin
      if (hit_o) value_d = next_i;
    end else if (ctrl_i.rotate) begin
      value_d = (ctrl_i.count == CNT_W'(IDX + 1)) ? head_i : next_i;
    end else begin
      // no operation: entry and match flag hold
      value_d = value_q;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

endmodule : olid_cell

`default_nettype wire

@@ hdl/ordered_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed 32-bit values held in a chain of cells, with
// insert at tail, delete of the first match and dump from head to tail.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o, payload in_data_i (req_type, value).
//   out channel : out_valid_o / out_stall_i, payload out_data_o (status,
//                 entry_value, entry_count, last).
//   A transaction moves when valid is high and stall is low at a clock edge.
// Sequencing:
//   One request is worked on at a time. Insert and dump of an empty list
//   are answered when the request is taken; an ignored request type gives
//   no result. Delete compares in every cell, then closes the gap behind
//   the first match through the chain; a dump of N entries takes a start
//   step, then one rotation of the chain per result.
//   The next request is taken once the final result is in the output
//   register and that register can be reloaded.
// Stall: results wait in the output register; the chain holds still and
//   further requests are stalled until the register can be reloaded.
// Reset: the list is empty after reset; no clearing pass is needed since
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_data_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             out_free, in_acc;
  cell_ctrl_t       ctrl;

  logic [DATA_W-1:0] vals [CAPACITY];
  logic [CAPACITY:0] hits;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Cell chain
  assign hits[0] = 1'b0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] nxt;
    if (g == CAPACITY - 1) begin : g_tail
      assign nxt = vals[g];
    end else begin : g_mid
      assign nxt = vals[g+1];
    end
    olid_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .next_i  (nxt),
      .head_i  (vals[0]),
      .hit_i   (hits[g]),
      .value_o (vals[g]),
      .hit_o   (hits[g+1])
    );
  end

  // Sequencer, chain control and result formation
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctrl        = '{insert: 1'b0, compare: 1'b0, remove: 1'b0, rotate: 1'b0,
                    count: count_q, value: in_data_i.value};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.req_type)
            REQ_INSERT: begin
              out_valid_d = 1'b1;
              if (count_q >= CNT_W'(CAPACITY)) begin
                out_d = '{status: STAT_FULL, entry_value: '0,
                          entry_count: count_q, last: 1'b1};
              end else begin
                ctrl.insert = 1'b1;
                count_d     = count_q + CNT_W'(1);
                out_d = '{status: STAT_DONE, entry_value: '0,
                          entry_count: count_d, last: 1'b1};
              end
            end
            REQ_DELETE: begin
              ctrl.compare = 1'b1;
              state_d      = ST_DEL;
            end
            REQ_DUMP: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_d = '{status: STAT_EMPTY, entry_value: '0,
                          entry_count: '0, last: 1'b1};
              end else begin
                left_d  = count_q;
                state_d = ST_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (hits[CAPACITY]) begin
            ctrl.remove = 1'b1;
            count_d     = count_q - CNT_W'(1);
            out_d = '{status: STAT_DONE, entry_value: '0,
                      entry_count: count_d, last: 1'b1};
          end else begin
            out_d = '{status: STAT_NOT_FOUND, entry_value: '0,
                      entry_count: count_q, last: 1'b1};
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.rotate = 1'b1;
          out_valid_d = 1'b1;
          out_d = '{status: STAT_ENTRY, entry_value: vals[0],
                    entry_count: count_q, last: (left_q == CNT_W'(1))};
          left_d = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE) else $error("request taken while busy");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)) else $error("count above capacity");

  a_dump_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> (left_q != '0) && (left_q <= count_q))
    else $error("dump counter out of range");

  a_dump_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && out_free && left_q == CNT_W'(1)) |=> state_q == ST_IDLE)
    else $error("dump did not finish after last entry");

  a_del_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEL |=> state_q == ST_IDLE || state_q == ST_DEL)
    else $error("delete left to wrong state");

endmodule : ordered_list_insert_delete

`default_nettype wire
